// ===== hw/rtl/apg_pkg.sv =====
// Package: register indexes, widths, CORDIC constants and the arctangent table.
package apg_pkg;

  localparam int CordicStages = 16;
  localparam int MaxPoints = 4096;
  localparam int DivSteps = 17;

  typedef enum logic [2:0] {
    REG_RADIUS      = 3'd0,
    REG_CENTER_X    = 3'd1,
    REG_CENTER_Y    = 3'd2,
    REG_START_ANGLE = 3'd3,
    REG_END_ANGLE   = 3'd4,
    REG_POINT_COUNT = 3'd5
  } reg_index_t;

  localparam logic [29:0] GainQ30 = 30'd652032874;
  localparam logic signed [34:0] OutMax = 35'sd8388607;
  localparam logic signed [34:0] OutMin = -35'sd8388608;
  // ceil(2^41 / 25): |r| * ZRecip >> 19 gives |r| * 2^24 / 100, truncated
  localparam logic [36:0] ZRecip = 37'd87960930223;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0: v = 32'sd754974720;
      5'd1: v = 32'sd445687602;
      5'd2: v = 32'sd235489088;
      5'd3: v = 32'sd119537938;
      5'd4: v = 32'sd60000934;
      5'd5: v = 32'sd30029717;
      5'd6: v = 32'sd15018523;
      5'd7: v = 32'sd7509720;
      5'd8: v = 32'sd3754917;
      5'd9: v = 32'sd1877466;
      5'd10: v = 32'sd938734;
      5'd11: v = 32'sd469367;
      5'd12: v = 32'sd234684;
      5'd13: v = 32'sd117342;
      5'd14: v = 32'sd58671;
      5'd15: v = 32'sd29335;
      5'd16: v = 32'sd14668;
      5'd17: v = 32'sd7334;
      5'd18: v = 32'sd3667;
      5'd19: v = 32'sd1833;
      5'd20: v = 32'sd917;
      5'd21: v = 32'sd458;
      5'd22: v = 32'sd229;
      5'd23: v = 32'sd115;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/arc_point_generator_unit.sv =====
// Top level: pipelined arc point generator (interpolation, divider, CORDIC).
//
// One point index is taken per cycle while the output is not stalled, and its point
// passes in order through interpolation, a restoring divider (one quotient
// bit per stage), angle reduction, 16 CORDIC stages, and rounding and
// saturation. The whole
// pipeline advances only when its last stage is free, so a stall holds every
// item in place. Configuration must be written only while the pipeline is empty.
module arc_point_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // point_index[11:0], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // point_x[23:0], point_y[47:24]
  output logic        m_axis_tuser,   // index_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int NS = apg_pkg::CordicStages;
  localparam int ND = apg_pkg::DivSteps;

  logic [15:0]        radius;
  logic signed [23:0] center_x, center_y;
  logic signed [16:0] start_angle, end_angle;
  logic [12:0]        point_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd256;
      center_x <= '0;
      center_y <= '0;
      start_angle <= '0;
      end_angle <= 17'sd9000;
      point_count <= 13'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        apg_pkg::REG_RADIUS:      radius <= cfg_data[15:0];
        apg_pkg::REG_CENTER_X:    center_x <= cfg_data;
        apg_pkg::REG_CENTER_Y:    center_y <= cfg_data;
        apg_pkg::REG_START_ANGLE: start_angle <= cfg_data[16:0];
        apg_pkg::REG_END_ANGLE:   end_angle <= cfg_data[16:0];
        apg_pkg::REG_POINT_COUNT: point_count <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // interpolation stage 1: products
  logic [12:0] cnt_eff;
  assign cnt_eff = (point_count > 13'(apg_pkg::MaxPoints)) ? 13'(apg_pkg::MaxPoints)
                                                         : point_count;
  logic               v1, e1, one1;
  logic signed [29:0] pa1, pb1;
  logic [11:0]        den1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_axis_tvalid;
    if (adv) begin
      e1 <= {1'b0, s_axis_tdata[11:0]} >= cnt_eff;
      one1 <= cnt_eff == 13'd1;
      den1 <= 12'(cnt_eff - 13'd1);
      pa1 <= $signed({1'b0, 12'(cnt_eff - 13'd1 - {1'b0, s_axis_tdata[11:0]})}) * start_angle;
      pb1 <= $signed({1'b0, s_axis_tdata[11:0]}) * end_angle;
    end
  end

  // interpolation stage 2: sum, sign split
  logic               v2, e2, one2, n2;
  logic [29:0]        num2;
  logic [11:0]        den2;
  logic signed [16:0] sa2;
  logic signed [30:0] sum1;
  assign sum1 = 31'(pa1) + 31'(pb1);
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      e2 <= e1; one2 <= one1; den2 <= den1; sa2 <= start_angle;
      n2 <= sum1[30];
      num2 <= 30'(sum1[30] ? -sum1 : sum1);
    end
  end

  // restoring divider, one quotient bit per stage (quotient < 2^17)
  logic               dv [ND+1];
  logic               de [ND+1], done_ [ND+1], dn [ND+1];
  logic [11:0]        dd [ND+1];
  logic [29:0]        dq [ND+1];
  logic [12:0]        drem [ND+1];
  logic signed [16:0] dsa [ND+1];
  always_comb begin
    dv[0] = v2; de[0] = e2; done_[0] = one2; dn[0] = n2; dd[0] = den2;
    dq[0] = num2; drem[0] = '0; dsa[0] = sa2;
  end
  // numerator < 2^30 but quotient fits in 17 bits: preload top 13 bits
  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [29:0] rt;
    logic [12:0] tr;
    logic [12:0] diff;
    always_comb begin
      if (k == 0) begin
        tr = '0;
        rt = dq[0];
      end else begin
        tr = drem[k];
        rt = dq[k];
      end
    end
    logic [29:0] trial;
    logic [29:0] rr;
    logic [29:0] qn;
    logic ge;
    always_comb begin
      rr = (k == 0) ? (rt >> ND) : {17'd0, tr};
      trial = {rr[28:0], rt[ND-1-k]};
      diff = 13'(trial - {18'd0, dd[k]});
    end
    assign ge = trial >= {18'd0, dd[k]};
    always_comb begin
      qn = rt;
      qn[ND-1-k] = ge;
    end
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) dv[k+1] <= dv[k];
      if (adv) begin
        de[k+1] <= de[k]; done_[k+1] <= done_[k]; dn[k+1] <= dn[k];
        dd[k+1] <= dd[k]; dsa[k+1] <= dsa[k];
        drem[k+1] <= ge ? diff : 13'(trial);
        dq[k+1] <= qn;
      end
    end
  end

  // angle: quotient with sign, or start angle for a single point
  logic signed [17:0] ang;
  always_comb begin
    if (done_[ND]) ang = 18'(dsa[ND]);
    else if (dn[ND]) ang = -$signed({1'b0, dq[ND][ND-1:0]});
    else ang = $signed({1'b0, dq[ND][ND-1:0]});
  end

  // reduction stage A: wrap into (-18000, 18000]
  logic               va, ea;
  logic signed [17:0] ra;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= dv[ND];
    if (adv) begin
      ea <= de[ND];
      if (ang > 18'sd54000) ra <= ang - 18'sd72000;
      else if (ang > 18'sd18000) ra <= ang - 18'sd36000;
      else if (ang <= -18'sd54000) ra <= ang + 18'sd72000;
      else if (ang <= -18'sd18000) ra <= ang + 18'sd36000;
      else ra <= ang;
    end
  end

  // CORDIC pipeline registers
  logic               cv [NS+1], ce [NS+1], cn [NS+1];
  logic signed [47:0] cx [NS+1], cy [NS+1];
  logic signed [31:0] cz [NS+1];

  // reduction stage B: fold to [-9000, 9000], scale to 2^-24 degree
  logic               vb, eb, nb;
  logic signed [17:0] rb;
  logic signed [31:0] zb;
  logic signed [47:0] x0;
  always_comb begin
    nb = 1'b0; rb = ra;
    if (ra > 18'sd9000) begin rb = ra - 18'sd18000; nb = 1'b1; end
    else if (ra < -18'sd9000) begin rb = ra + 18'sd18000; nb = 1'b1; end
  end
  logic [13:0] rmag;
  logic [50:0] zprod;
  logic [31:0] zq;
  assign rmag = 14'(rb[17] ? -rb : rb);
  assign zprod = 51'(rmag) * 51'(apg_pkg::ZRecip);
  assign zq = zprod[50:19];
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (adv) vb <= va;
    if (adv) begin
      eb <= ea;
      zb <= rb[17] ? -$signed(zq) : $signed(zq);
      cn[0] <= nb;
    end
  end
  always_ff @(posedge clk) begin
    x0 <= $signed({2'b0, 46'(radius) * 46'(apg_pkg::GainQ30)});
  end

  // CORDIC stages
  always_comb begin
    cv[0] = vb; ce[0] = eb; cz[0] = zb; cx[0] = x0; cy[0] = '0;
  end
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [47:0] dxs, dys;
    assign dxs = cy[i] >>> i;
    assign dys = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
      if (adv) begin
        ce[i+1] <= ce[i]; cn[i+1] <= cn[i];
        if (!cz[i][31]) begin
          cx[i+1] <= cx[i] - dxs; cy[i+1] <= cy[i] + dys;
          cz[i+1] <= cz[i] - apg_pkg::atan_entry(5'(i));
        end else begin
          cx[i+1] <= cx[i] + dxs; cy[i+1] <= cy[i] - dys;
          cz[i+1] <= cz[i] + apg_pkg::atan_entry(5'(i));
        end
      end
    end
  end

  // rounding
  logic               vr, er;
  logic signed [34:0] rx, ry;
  logic signed [47:0] sx, sy;
  assign sx = cn[NS] ? -cx[NS] : cx[NS];
  assign sy = cn[NS] ? -cy[NS] : cy[NS];
  always_ff @(posedge clk) begin
    if (rst) vr <= 1'b0;
    else if (adv) vr <= cv[NS];
    if (adv) begin
      er <= ce[NS];
      rx <= 35'((sx + 48'sd536870912) >>> 30) + 35'(center_x);
      ry <= 35'((sy + 48'sd536870912) >>> 30) + 35'(center_y);
    end
  end

  // saturate into output register
  logic signed [23:0] ox, oy;
  assign ox = (rx > apg_pkg::OutMax) ? 24'sh7FFFFF :
              (rx < apg_pkg::OutMin) ? 24'sh800000 : rx[23:0];
  assign oy = (ry > apg_pkg::OutMax) ? 24'sh7FFFFF :
              (ry < apg_pkg::OutMin) ? 24'sh800000 : ry[23:0];
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= vr;
    if (adv) begin
      m_axis_tuser <= er;
      m_axis_tdata <= er ? 48'd0 : {oy, ox};
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("error item carries nonzero point");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled item changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

endmodule
